/* hdl/command_frame_receiver_macros.svh */
// Assertion helpers shared by the frame receiver modules.
`ifndef COMMAND_FRAME_RECEIVER_MACROS_SVH
`define COMMAND_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CFR_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("cfr same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CFR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("cfr next-cycle check failed");

`endif

/* hdl/cfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hFF;
    localparam logic [7:0] HDR_SECOND = 8'hAA;

    localparam logic [7:0] CMD_VELOCITY  = 8'h04;
    localparam logic [7:0] CMD_IMU       = 8'h05;
    localparam logic [7:0] CMD_INTAKE    = 8'h06;
    localparam logic [7:0] CMD_ELEVATOR  = 8'h08;
    localparam logic [7:0] CMD_WAREHOUSE = 8'h0A;
    localparam logic [7:0] CMD_SIMPLE_00 = 8'h00;
    localparam logic [7:0] CMD_SIMPLE_02 = 8'h02;
    localparam logic [7:0] CMD_SIMPLE_03 = 8'h03;
    localparam logic [7:0] CMD_SIMPLE_0B = 8'h0B;
    localparam logic [7:0] CMD_SIMPLE_0D = 8'h0D;
    localparam logic [7:0] CMD_SIMPLE_13 = 8'h13;

    localparam logic [7:0] SIZE_VELOCITY = 8'd13;
    localparam logic [7:0] SIZE_SENSOR   = 8'd5;
    localparam logic [7:0] SIZE_SIMPLE   = 8'd1;
    localparam logic [7:0] SIZE_UNKNOWN  = 8'd0;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CHECKSUM  = 3'd1;
    localparam logic [2:0] ST_SIZE      = 3'd2;
    localparam logic [2:0] ST_UNKNOWN   = 3'd3;
    localparam logic [2:0] ST_OVERSIZED = 3'd4;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        FS_HUNT,
        FS_HDR2,
        FS_SIZE,
        FS_CMD,
        FS_BODY
    } t_front_state;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_EMIT,
        BS_READ,
        BS_DATA
    } t_back_state;

    // one finished frame, handed from the front to the back
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] cmd;
        logic [7:0] plen;
    } t_job;

    // payload store write port
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } t_wr;

    // what the front needs to know about the queue and the back
    typedef struct packed {
        logic q_full;
        logic q_empty;
        logic back_busy;
    } t_front_ctl;

    function automatic logic [7:0] needed_size(input logic [7:0] cmd);
        logic [7:0] need;
        unique case (cmd) inside
            CMD_VELOCITY:
                need = SIZE_VELOCITY;
            CMD_IMU, CMD_INTAKE, CMD_ELEVATOR, CMD_WAREHOUSE:
                need = SIZE_SENSOR;
            CMD_SIMPLE_00, CMD_SIMPLE_02, CMD_SIMPLE_03,
            CMD_SIMPLE_0B, CMD_SIMPLE_0D, CMD_SIMPLE_13:
                need = SIZE_SIMPLE;
            default:
                need = SIZE_UNKNOWN;
        endcase
        return need;
    endfunction

endpackage

`default_nettype wire

/* hdl/command_frame_receiver.sv */
// Path: with the back end idle, a status-only result, once its last byte (check byte, or
// command byte for size-zero and oversized frames) is accepted, passes the queue, the back
// end's emit state and the output register; a payload byte takes the read and data states.
// Throughput: one byte per cycle while hunting; payload results alternate store read and
// output load, set by the registered read; payload beats stall until the store is drained.
// Reset: synchronous, active low; clears the parser, queue and output valid, not the store.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_receiver #(
    parameter int PAYLOAD_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_frame_status,
    output logic [7:0]       o_command_code,
    output logic             o_has_data,
    output logic [7:0]       o_data_byte,
    output logic             o_last
);
    import cfr_pkg::*;

    t_front_ctl ctl;
    t_job       push_job;
    t_job       pop_job;
    t_wr        wr;
    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;
    logic       back_busy;

    assign ctl.q_full    = q_full;
    assign ctl.q_empty   = q_empty;
    assign ctl.back_busy = back_busy;

    cfr_front #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_ctl     (ctl),
        .o_push    (push),
        .o_job     (push_job),
        .o_wr      (wr)
    );

    cfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    cfr_back #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (wr),
        .i_job_valid    (!q_empty),
        .i_job          (pop_job),
        .o_pop          (pop),
        .o_busy         (back_busy),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_status (o_frame_status),
        .o_command_code (o_command_code),
        .o_has_data     (o_has_data),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

/* hdl/cfr_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "command_frame_receiver_macros.svh"

module cfr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  cfr_pkg::t_job      i_job,
    input  wire logic          i_pop,
    output cfr_pkg::t_job      o_job,
    output logic               o_empty,
    output logic               o_full
);
    import cfr_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(QUEUE_DEPTH));

    `CFR_ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, i_push, r_count != CW'(QUEUE_DEPTH))
    `CFR_ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

`default_nettype wire

/* hdl/cfr_front.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "command_frame_receiver_macros.svh"

module cfr_front #(
    parameter int PAYLOAD_DEPTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_rx_byte,
    input  cfr_pkg::t_front_ctl i_ctl,
    output logic               o_push,
    output cfr_pkg::t_job      o_job,
    output cfr_pkg::t_wr       o_wr
);
    import cfr_pkg::*;

    localparam int CW = $clog2(PAYLOAD_DEPTH + 1);
    localparam logic [7:0] SIZE_LIMIT = 8'(PAYLOAD_DEPTH + 1);

    t_front_state   r_state, n_state;
    logic [7:0]     r_size, n_size;
    logic [7:0]     r_cmd, n_cmd;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           accept;
    logic [7:0]     plen;
    logic [7:0]     need;
    logic [2:0]     status;

    assign plen = r_size - 8'd1;
    assign need = needed_size(r_cmd);

    // checksum first, then known command, then size
    always_comb begin
        if (i_rx_byte != r_cmd + 8'd1) begin
            status = ST_CHECKSUM;
        end else if (need == SIZE_UNKNOWN) begin
            status = ST_UNKNOWN;
        end else if (r_size != need) begin
            status = ST_SIZE;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        n_state = r_state;
        n_size  = r_size;
        n_cmd   = r_cmd;
        n_cnt   = r_cnt;
        o_push  = 1'b0;
        o_job   = '0;
        o_wr    = '0;
        o_stall = 1'b0;

        unique case (r_state)
            FS_CMD:  o_stall = i_ctl.q_full;
            // hold payload beats until the store is free of the previous frame
            FS_BODY: o_stall = !(i_ctl.q_empty && !i_ctl.back_busy);
            default: o_stall = 1'b0;
        endcase

        accept = i_valid && !o_stall;

        unique case (r_state)
            FS_HUNT: begin
                if (accept && i_rx_byte == HDR_FIRST) begin
                    n_state = FS_HDR2;
                end
            end
            FS_HDR2: begin
                if (accept) begin
                    n_state = (i_rx_byte == HDR_SECOND) ? FS_SIZE : FS_HUNT;
                end
            end
            FS_SIZE: begin
                if (accept) begin
                    n_size  = i_rx_byte;
                    n_state = FS_CMD;
                end
            end
            FS_CMD: begin
                if (accept) begin
                    n_cmd = i_rx_byte;
                    n_cnt = '0;
                    if (r_size == 8'd0) begin
                        // command byte doubles as the check byte: always a mismatch
                        o_push       = 1'b1;
                        o_job.status = ST_CHECKSUM;
                        o_job.cmd    = i_rx_byte;
                        n_state      = FS_HUNT;
                    end else if (r_size > SIZE_LIMIT) begin
                        o_push       = 1'b1;
                        o_job.status = ST_OVERSIZED;
                        o_job.cmd    = i_rx_byte;
                        n_state      = FS_HUNT;
                    end else begin
                        n_state = FS_BODY;
                    end
                end
            end
            FS_BODY: begin
                if (accept) begin
                    if (8'(r_cnt) < plen) begin
                        o_wr.en   = 1'b1;
                        o_wr.addr = 8'(r_cnt);
                        o_wr.data = i_rx_byte;
                        n_cnt     = r_cnt + CW'(1);
                    end else begin
                        o_push       = 1'b1;
                        o_job.status = status;
                        o_job.cmd    = r_cmd;
                        o_job.plen   = plen;
                        n_state      = FS_HUNT;
                    end
                end
            end
            default: n_state = FS_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_HUNT;
            r_size  <= '0;
            r_cmd   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_size  <= n_size;
            r_cmd   <= n_cmd;
            r_cnt   <= n_cnt;
        end
    end

    `CFR_ASSERT_IMPLY(a_wr_store_free, i_clk, i_rst_n, o_wr.en, i_ctl.q_empty && !i_ctl.back_busy)

endmodule

`default_nettype wire

/* hdl/cfr_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "command_frame_receiver_macros.svh"

module cfr_back #(
    parameter int PAYLOAD_DEPTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  cfr_pkg::t_wr       i_wr,
    input  wire logic          i_job_valid,
    input  cfr_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_busy,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [2:0]         o_frame_status,
    output logic [7:0]         o_command_code,
    output logic               o_has_data,
    output logic [7:0]         o_data_byte,
    output logic               o_last
);
    import cfr_pkg::*;

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    logic [7:0]     r_mem [PAYLOAD_DEPTH];
    logic [7:0]     r_rd_data;

    t_back_state    r_state, n_state;
    t_job           r_job, n_job;
    logic [AW-1:0]  r_idx, n_idx;

    logic           r_o_valid;
    logic [2:0]     r_status;
    logic [7:0]     r_cmd;
    logic           r_has;
    logic [7:0]     r_data;
    logic           r_last;

    logic           out_free;
    logic           load;
    logic [2:0]     ld_status;
    logic           ld_has;
    logic [7:0]     ld_data;
    logic           ld_last;
    logic           last_hit;

    assign out_free = !r_o_valid || !i_stall;
    assign last_hit = (8'(r_idx) + 8'd1 == r_job.plen);

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_idx     = r_idx;
        o_pop     = 1'b0;
        load      = 1'b0;
        ld_status = ST_OK;
        ld_has    = 1'b0;
        ld_data   = '0;
        ld_last   = 1'b1;

        unique case (r_state)
            BS_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_idx   = '0;
                    n_state = (i_job.status == ST_OK && i_job.plen != 8'd0) ?
                              BS_READ : BS_EMIT;
                end
            end
            BS_EMIT: begin
                if (out_free) begin
                    load      = 1'b1;
                    ld_status = r_job.status;
                    n_state   = BS_IDLE;
                end
            end
            BS_READ: begin
                n_state = BS_DATA;
            end
            BS_DATA: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_has  = 1'b1;
                    ld_data = r_rd_data;
                    ld_last = last_hit;
                    if (last_hit) begin
                        n_state = BS_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = BS_READ;
                    end
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_idx <= n_idx;
        if (load) begin
            r_status <= ld_status;
            r_cmd    <= r_job.cmd;
            r_has    <= ld_has;
            r_data   <= ld_data;
            r_last   <= ld_last;
        end
    end

    // payload store: one write port from the front, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[AW-1:0]] <= i_wr.data;
        end
        if (r_state == BS_READ) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    assign o_busy         = (r_state != BS_IDLE);
    assign o_valid        = r_o_valid;
    assign o_frame_status = r_status;
    assign o_command_code = r_cmd;
    assign o_has_data     = r_has;
    assign o_data_byte    = r_data;
    assign o_last         = r_last;

    `CFR_ASSERT_IMPLY(a_data_only_ok, i_clk, i_rst_n, r_o_valid && r_has, r_status == ST_OK)
    `CFR_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, r_state == BS_DATA && out_free && last_hit, r_state == BS_IDLE)

endmodule

`default_nettype wire

/* bench/tb_command_frame_receiver.sv */
`timescale 1ns / 1ps

module tb_command_frame_receiver;
    import cfr_pkg::*;

    localparam int PAYLOAD_DEPTH = 16;

    // parser position: header, size, command, then payload and check byte
    localparam int POS_HUNT = 0;
    localparam int POS_HDR2 = 1;
    localparam int POS_SIZE = 2;
    localparam int POS_CMD  = 3;
    localparam int POS_BODY = 4;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] cmd;
        logic       has_data;
        logic [7:0] data;
        logic       last;
    } t_frame_beat;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_stall   = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [2:0] o_frame_status;
    logic [7:0] o_command_code;
    logic       o_has_data;
    logic [7:0] o_data_byte;
    logic       o_last;

    // predicted parser state
    int         rx_pos = POS_HUNT;
    logic [7:0] rx_size = 8'h00;
    logic [7:0] rx_cmd = 8'h00;
    logic [7:0] rx_body [PAYLOAD_DEPTH];

    t_frame_beat pending_beats [$];
    int          send_idle = 26;
    int          recv_idle = 82;
    int          active_bytes = 0;
    int          err_count = 0;

    command_frame_receiver #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_frame_status (o_frame_status),
        .o_command_code (o_command_code),
        .o_has_data     (o_has_data),
        .o_data_byte    (o_data_byte),
        .o_last         (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [7:0] required_size(input logic [7:0] cmd);
        case (cmd)
            CMD_VELOCITY:
                return SIZE_VELOCITY;
            CMD_IMU, CMD_INTAKE, CMD_ELEVATOR, CMD_WAREHOUSE:
                return SIZE_SENSOR;
            CMD_SIMPLE_00, CMD_SIMPLE_02, CMD_SIMPLE_03,
            CMD_SIMPLE_0B, CMD_SIMPLE_0D, CMD_SIMPLE_13:
                return SIZE_SIMPLE;
            default:
                return SIZE_UNKNOWN;
        endcase
    endfunction

    task automatic push_beat(input logic [2:0] status, input logic has_data,
                             input logic [7:0] data, input logic last);
        t_frame_beat beat;
        beat.status   = status;
        beat.cmd      = rx_cmd;
        beat.has_data = has_data;
        beat.data     = data;
        beat.last     = last;
        pending_beats.push_back(beat);
    endtask

    // Judge a finished frame on its check byte: checksum, then command, then size.
    task automatic close_frame(input logic [7:0] check);
        int         body_len;
        logic [2:0] status;
        body_len = int'(rx_size) - 1;
        rx_pos = POS_HUNT;
        if (check != rx_cmd + 8'd1)
            status = ST_CHECKSUM;
        else if (required_size(rx_cmd) == SIZE_UNKNOWN)
            status = ST_UNKNOWN;
        else if (rx_size != required_size(rx_cmd))
            status = ST_SIZE;
        else
            status = ST_OK;
        if (status != ST_OK || body_len == 0) begin
            push_beat(status, 1'b0, 8'h00, 1'b1);
        end else begin
            for (int i = 0; i < body_len; i++)
                push_beat(ST_OK, 1'b1, rx_body[i], i == body_len - 1);
        end
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        int k;
        case (rx_pos)
            POS_HUNT: begin
                if (b == HDR_FIRST)
                    rx_pos = POS_HDR2;
            end
            POS_HDR2: begin
                // a bad second byte is not retried as a first header byte
                rx_pos = (b == HDR_SECOND) ? POS_SIZE : POS_HUNT;
            end
            POS_SIZE: begin
                rx_size = b;
                rx_pos = POS_CMD;
            end
            POS_CMD: begin
                rx_cmd = b;
                if (rx_size == 8'h00) begin
                    rx_pos = POS_HUNT;
                    push_beat(ST_CHECKSUM, 1'b0, 8'h00, 1'b1);
                end else if (int'(rx_size) - 1 > PAYLOAD_DEPTH) begin
                    rx_pos = POS_HUNT;
                    push_beat(ST_OVERSIZED, 1'b0, 8'h00, 1'b1);
                end else begin
                    rx_pos = POS_BODY;
                end
            end
            default: begin
                k = rx_pos - POS_BODY;
                if (k < int'(rx_size) - 1) begin
                    rx_body[k] = b;
                    rx_pos++;
                end else begin
                    close_frame(b);
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        if (rx_pos != POS_HUNT || b == HDR_FIRST)
            active_bytes++;
        parse_rx_byte(b);
    endtask

    // Payload alternates fill and ~fill unless random content is asked for.
    task automatic send_frame(input logic [7:0] size, input logic [7:0] cmd,
                              input logic [7:0] check, input bit rand_body,
                              input logic [7:0] fill);
        int body_len;
        body_len = int'(size) - 1;
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(size);
        send_byte(cmd);
        if (size == 8'h00 || body_len > PAYLOAD_DEPTH)
            return;
        for (int i = 0; i < body_len; i++)
            send_byte(rand_body ? 8'($urandom) : (i[0] ? ~fill : fill));
        send_byte(check);
    endtask

    // drop valid so the last byte is not taken again while waiting
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        err_count++;
    endtask

    always @(posedge i_clk) begin : check_beats
        t_frame_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual status %0d cmd %0d",
                         $time, o_frame_status, o_command_code);
                err_count++;
            end else begin
                want = pending_beats.pop_front();
                if (o_frame_status !== want.status)
                    report_field("frame_status", want.status, o_frame_status);
                if (o_command_code !== want.cmd)
                    report_field("command_code", want.cmd, o_command_code);
                if (o_has_data !== want.has_data)
                    report_field("has_data", want.has_data, o_has_data);
                if (o_data_byte !== want.data)
                    report_field("data_byte", want.data, o_data_byte);
                if (o_last !== want.last)
                    report_field("last", want.last, o_last);
            end
        end
        i_stall <= ($urandom_range(99) < recv_idle);
    end

    task automatic test_header_sync();
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(HDR_FIRST);
        send_byte(8'h12);
        // second FF fails as header byte two; the AA after it is just noise
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_frame(SIZE_SIMPLE, CMD_SIMPLE_00, CMD_SIMPLE_00 + 8'd1, 1'b0, 8'h00);
        wait_drained();
    endtask

    task automatic test_rejected_frames();
        send_frame(8'h00, 8'h07, 8'h00, 1'b0, 8'h00);
        send_frame(8'hFF, CMD_IMU, 8'h00, 1'b0, 8'h00);
        send_frame(8'(PAYLOAD_DEPTH + 2), CMD_VELOCITY, 8'h00, 1'b0, 8'h00);
        send_frame(SIZE_SIMPLE, CMD_SIMPLE_02, 8'h00, 1'b0, 8'h00);
        // command FF: check byte wraps to 00, so only the command is wrong
        send_frame(SIZE_SIMPLE, 8'hFF, 8'h00, 1'b0, 8'h00);
        send_frame(SIZE_SENSOR, CMD_SIMPLE_13, CMD_SIMPLE_13 + 8'd1, 1'b0, 8'h5A);
        wait_drained();
    endtask

    task automatic test_accepted_frames();
        send_frame(SIZE_VELOCITY, CMD_VELOCITY, CMD_VELOCITY + 8'd1, 1'b0, 8'h00);
        send_frame(SIZE_SENSOR, CMD_WAREHOUSE, CMD_WAREHOUSE + 8'd1, 1'b0, 8'hFF);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int s_idle, input int r_idle, input int target);
        int         start;
        int         pick;
        logic [7:0] cmd;
        logic [7:0] size;
        logic [7:0] check;
        send_idle = s_idle;
        recv_idle = r_idle;
        start = active_bytes;
        while (active_bytes - start < target) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 4))
                    send_byte(($urandom_range(3) == 0) ? HDR_FIRST : 8'($urandom));
            end else if (pick < 16) begin
                send_byte(HDR_FIRST);
                send_byte(8'($urandom));
            end else begin
                if ($urandom_range(99) < 85) begin
                    case ($urandom_range(10))
                        0: cmd = CMD_VELOCITY;
                        1: cmd = CMD_IMU;
                        2: cmd = CMD_INTAKE;
                        3: cmd = CMD_ELEVATOR;
                        4: cmd = CMD_WAREHOUSE;
                        5: cmd = CMD_SIMPLE_00;
                        6: cmd = CMD_SIMPLE_02;
                        7: cmd = CMD_SIMPLE_03;
                        8: cmd = CMD_SIMPLE_0B;
                        9: cmd = CMD_SIMPLE_0D;
                        default: cmd = CMD_SIMPLE_13;
                    endcase
                end else begin
                    cmd = 8'($urandom);
                end
                pick = $urandom_range(99);
                if (pick < 70)
                    size = (required_size(cmd) != SIZE_UNKNOWN) ? required_size(cmd)
                                                                : 8'($urandom_range(1, 6));
                else if (pick < 90)
                    size = 8'($urandom_range(0, PAYLOAD_DEPTH + 2));
                else
                    size = 8'($urandom_range(PAYLOAD_DEPTH + 2, 255));
                check = ($urandom_range(99) < 85) ? cmd + 8'd1 : 8'($urandom);
                send_frame(size, cmd, check, 1'b1, 8'h00);
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_header_sync();
        test_rejected_frames();
        test_accepted_frames();
        test_random_traffic(26, 82, 117);
        test_random_traffic(82, 26, 117);
        test_random_traffic(0, 0, 117);
        wait_drained();
        if (err_count == 0 && pending_beats.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* command_frame_receiver.f */
+incdir+hdl
hdl/cfr_pkg.sv
hdl/cfr_queue.sv
hdl/cfr_front.sv
hdl/cfr_back.sv
hdl/command_frame_receiver.sv
bench/tb_command_frame_receiver.sv
